// ----- hw/rtl/jvsi_pkg.sv -----
package jvsi_pkg;

    localparam int FRAC_BITS_DEF        = 16;
    localparam int ANGLE_ITERATIONS_DEF = 16;
    localparam int CFG_IDX_W            = 3;
    localparam int CFG_DATA_W           = 31;

    localparam logic signed [35:0] PI_Q16       = 36'sd205887;
    localparam logic signed [35:0] HALF_PI_Q16  = 36'sd102944;
    localparam logic signed [35:0] TWO_PI_Q16   = 36'sd411775;
    localparam logic signed [35:0] YAW_NEAR_Q16 = 36'sd32768;
    localparam logic signed [35:0] YAW_FAR_Q16  = 36'sd380109;
    localparam logic signed [31:0] GAIN_Q24     = 32'sd10188014;

    typedef enum logic [1:0] {
        KIND_JOY  = 2'd0,
        KIND_ODOM = 2'd1,
        KIND_TICK = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_DEAD_ZONE  = 3'd0,
        REG_PLANAR_MAX = 3'd1,
        REG_VERT_MAX   = 3'd2,
        REG_YAW_MAX    = 3'd3,
        REG_ERR_X      = 3'd4,
        REG_ERR_Y      = 3'd5,
        REG_ERR_Z      = 3'd6,
        REG_UNUSED     = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ODOM_PROD,
        ST_ODOM_SUM,
        ST_ODOM_CORDIC,
        ST_ODOM_DONE,
        ST_TICK_PROD,
        ST_TICK_STEP,
        ST_TICK_CORDIC,
        ST_TICK_MUL,
        ST_TICK_RND,
        ST_TICK_UPD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        CMODE_IDLE,
        CMODE_VECTOR,
        CMODE_ROTATE
    } cmode_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] axis_forward;
        logic signed [15:0] axis_vertical;
        logic signed [15:0] trigger_right;
        logic signed [15:0] trigger_left;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] set_x;
        logic signed [31:0] set_y;
        logic signed [31:0] set_z;
        logic [18:0]        set_yaw;
    } out_item_t;

    // control from sequencer to cordic unit
    typedef struct packed {
        logic   start;
        cmode_t mode;
    } cordic_ctl_t;

    // arctangent table, Q24
    function automatic logic signed [35:0] arctan_q24(input logic [4:0] i);
        logic signed [35:0] r;
        case (i)
            5'd0:  r = 36'sd13176795;
            5'd1:  r = 36'sd7778716;
            5'd2:  r = 36'sd4110060;
            5'd3:  r = 36'sd2086331;
            5'd4:  r = 36'sd1047214;
            5'd5:  r = 36'sd524117;
            5'd6:  r = 36'sd262123;
            5'd7:  r = 36'sd131069;
            5'd8:  r = 36'sd65536;
            5'd9:  r = 36'sd32768;
            5'd10: r = 36'sd16384;
            5'd11: r = 36'sd8192;
            5'd12: r = 36'sd4096;
            5'd13: r = 36'sd2048;
            5'd14: r = 36'sd1024;
            5'd15: r = 36'sd512;
            5'd16: r = 36'sd256;
            5'd17: r = 36'sd128;
            5'd18: r = 36'sd64;
            5'd19: r = 36'sd32;
            5'd20: r = 36'sd16;
            5'd21: r = 36'sd8;
            5'd22: r = 36'sd4;
            5'd23: r = 36'sd2;
            default: r = 36'sd0;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/jvsi_cordic.sv -----
module jvsi_cordic #(
    parameter int ITERS = jvsi_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  jvsi_pkg::cordic_ctl_t    ctl,
    input  logic signed [35:0]       x_init,
    input  logic signed [35:0]       y_init,
    input  logic signed [35:0]       z_init,
    output logic                     done,
    output logic signed [35:0]       x_out,
    output logic signed [35:0]       y_out,
    output logic signed [35:0]       z_out
);
    import jvsi_pkg::*;

    localparam int NIT = (ITERS > 24) ? 24 : ITERS;

    logic signed [35:0] x_reg, y_reg, z_reg;
    logic signed [35:0] x_next, y_next, z_next;
    logic [4:0]         i_reg, i_next;
    cmode_t             mode_reg, mode_next;
    logic               done_reg, done_next;
    logic signed [35:0] xs, ys, at;
    logic               plus, minus;

    // one micro-rotation per cycle
    always_comb
    begin
        xs        = x_reg >>> i_reg;
        ys        = y_reg >>> i_reg;
        at        = arctan_q24(i_reg);
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        mode_next = mode_reg;
        done_next = 1'b0;
        plus      = 1'b0;
        minus     = 1'b0;
        if (ctl.start)
        begin
            x_next    = x_init;
            y_next    = y_init;
            z_next    = z_init;
            i_next    = '0;
            mode_next = ctl.mode;
        end
        else if (mode_reg != CMODE_IDLE)
        begin
            if (mode_reg == CMODE_VECTOR)
            begin
                plus  = (y_reg > 0);
                minus = (y_reg < 0);
            end
            else
            begin
                minus = (z_reg >= 0);
                plus  = !(z_reg >= 0);
            end
            if (mode_reg == CMODE_VECTOR)
            begin
                if (plus)
                begin
                    x_next = x_reg + ys; y_next = y_reg - xs; z_next = z_reg + at;
                end
                else if (minus)
                begin
                    x_next = x_reg - ys; y_next = y_reg + xs; z_next = z_reg - at;
                end
            end
            else if (minus)
            begin
                x_next = x_reg - ys; y_next = y_reg + xs; z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys; y_next = y_reg - xs; z_next = z_reg + at;
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(NIT - 1))
            begin
                mode_next = CMODE_IDLE;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= CMODE_IDLE;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ----- hw/rtl/joystick_velocity_setpoint_integrator.sv -----
// joystick and odometry items only update internal state; a tick item passes through
// the cordic rotation, multiply, round and update steps to the result register
// throughput: one item at a time; set by the single shared cordic unit (one step a cycle)
// a finished result waits in the output register while the next item is taken
// reset: asynchronous active low; registers to defaults, desired z one meter
module joystick_velocity_setpoint_integrator #(
    parameter int FRAC_BITS        = jvsi_pkg::FRAC_BITS_DEF,
    parameter int ANGLE_ITERATIONS = jvsi_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  jvsi_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output jvsi_pkg::out_item_t             out_data,
    input  logic                            cfg_we,
    input  logic [jvsi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jvsi_pkg::CFG_DATA_W-1:0] cfg_data
);
    import jvsi_pkg::*;

    // configuration
    logic [14:0] dead_zone_reg;
    logic [15:0] planar_max_reg, vert_max_reg, yaw_max_reg;
    logic [30:0] err_x_reg, err_y_reg, err_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg  <= 15'd1638;
            planar_max_reg <= 16'd4369;
            vert_max_reg   <= 16'd2185;
            yaw_max_reg    <= 16'd765;
            err_x_reg      <= 31'd131072;
            err_y_reg      <= 31'd131072;
            err_z_reg      <= 31'd131072;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_DEAD_ZONE:  dead_zone_reg  <= cfg_data[14:0];
                REG_PLANAR_MAX: planar_max_reg <= cfg_data[15:0];
                REG_VERT_MAX:   vert_max_reg   <= cfg_data[15:0];
                REG_YAW_MAX:    yaw_max_reg    <= cfg_data[15:0];
                REG_ERR_X:      err_x_reg      <= cfg_data[30:0];
                REG_ERR_Y:      err_y_reg      <= cfg_data[30:0];
                REG_ERR_Z:      err_z_reg      <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // state
    state_t state_reg, state_next;
    logic signed [16:0] planar_reg, vert_reg, yawc_reg;
    logic signed [31:0] mx_reg, my_reg, mz_reg;
    logic [18:0]        myaw_reg;
    logic signed [31:0] dx_reg, dy_reg, dz_reg;
    logic [18:0]        dh_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;
    in_item_t           item_reg;

    // scratch registers
    logic signed [35:0] p0_reg, p1_reg, p2_reg;
    logic signed [35:0] offs_reg;
    logic signed [35:0] dl_reg, dzs_reg, dyaw_reg;
    logic               neg_reg;
    logic signed [63:0] mx_prod_reg, my_prod_reg;

    logic signed [16:0] planar_next, vert_next, yawc_next;
    logic signed [31:0] mx_next, my_next, mz_next, dx_next, dy_next, dz_next;
    logic [18:0]        myaw_next, dh_next;
    logic               out_valid_next;
    out_item_t          out_next;
    in_item_t           item_next;
    logic signed [35:0] p0_next, p1_next, p2_next, offs_next, dl_next, dzs_next, dyaw_next;
    logic               neg_next;
    logic signed [63:0] mx_prod_next, my_prod_next;

    cordic_ctl_t        cctl;
    logic signed [35:0] cx_in, cy_in, cz_in, cx, cy, cz;
    logic               cdone;

    jvsi_cordic #(.ITERS(ANGLE_ITERATIONS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .ctl(cctl),
        .x_init(cx_in), .y_init(cy_in), .z_init(cz_in),
        .done(cdone), .x_out(cx), .y_out(cy), .z_out(cz)
    );

    function automatic logic signed [16:0] gate(input logic signed [15:0] v,
                                                input logic [14:0] dz);
        logic [16:0] mag;
        mag = v[15] ? 17'(-{v[15], v}) : {1'b0, v};
        return (mag > {2'b0, dz}) ? {v[15], v} : 17'sd0;
    endfunction

    function automatic logic signed [31:0] sat(input logic signed [33:0] v);
        if (v > 34'sd2147483647)       return 32'sh7fffffff;
        else if (v < -34'sd2147483648) return 32'sh80000000;
        else                           return v[31:0];
    endfunction

    function automatic logic [31:0] absd(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        return d[32] ? 32'(-d) : d[31:0];
    endfunction

    logic               in_xfer;
    logic signed [16:0] gr, gl;
    logic signed [35:0] th, yaw_v, h, diff, zr;
    logic signed [26:0] rc, rs;
    logic signed [33:0] ax, ay, az;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        planar_next    = planar_reg;
        vert_next      = vert_reg;
        yawc_next      = yawc_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        mz_next        = mz_reg;
        myaw_next      = myaw_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dz_next        = dz_reg;
        dh_next        = dh_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        item_next      = item_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        offs_next      = offs_reg;
        dl_next        = dl_reg;
        dzs_next       = dzs_reg;
        dyaw_next      = dyaw_reg;
        neg_next       = neg_reg;
        mx_prod_next   = mx_prod_reg;
        my_prod_next   = my_prod_reg;
        cctl.start     = 1'b0;
        cctl.mode      = CMODE_IDLE;
        cx_in          = '0;
        cy_in          = '0;
        cz_in          = '0;
        gr             = gate(item_reg.trigger_right, dead_zone_reg);
        gl             = gate(item_reg.trigger_left, dead_zone_reg);
        th             = '0;
        yaw_v          = '0;
        h              = '0;
        diff           = '0;
        zr             = '0;
        rc             = '0;
        rs             = '0;
        ax             = '0;
        ay             = '0;
        az             = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    item_next = in_data;
                    case (kind_t'(in_data.kind))
                        KIND_JOY:
                        begin
                            gr = gate(in_data.trigger_right, dead_zone_reg);
                            gl = gate(in_data.trigger_left, dead_zone_reg);
                            planar_next = gate(in_data.axis_forward, dead_zone_reg);
                            vert_next   = gate(in_data.axis_vertical, dead_zone_reg);
                            yawc_next   = (gr != 0 && gl != 0) ? 17'(gr - gl) : 17'sd0;
                        end
                        KIND_ODOM: state_next = ST_ODOM_PROD;
                        KIND_TICK: state_next = ST_TICK_PROD;
                        default: ;
                    endcase
                end
            end
            // quaternion products
            ST_ODOM_PROD:
            begin
                p0_next = 36'(item_reg.quat_y * item_reg.quat_x)
                        - 36'(item_reg.quat_z * item_reg.quat_w);
                p1_next = 36'(item_reg.quat_y * item_reg.quat_y)
                        + 36'(item_reg.quat_w * item_reg.quat_w);
                state_next = ST_ODOM_SUM;
            end
            ST_ODOM_SUM:
            begin
                p0_next = p0_reg <<< 1;
                p1_next = (36'sd1 <<< 30) - (p1_reg <<< 1);
                state_next = ST_ODOM_CORDIC;
                cctl.start = 1'b1;
                cctl.mode  = CMODE_VECTOR;
                if (p1_next < 0)
                begin
                    cx_in     = -p1_next;
                    cy_in     = -p0_next;
                    offs_next = (p0_next >= 0) ? PI_Q16 : -PI_Q16;
                end
                else
                begin
                    cx_in     = p1_next;
                    cy_in     = p0_next;
                    offs_next = '0;
                end
            end
            ST_ODOM_CORDIC:
                if (cdone) state_next = ST_ODOM_DONE;
            ST_ODOM_DONE:
            begin
                yaw_v = ((cz + 36'sd128) >>> 8) + offs_reg + PI_Q16;
                if (yaw_v < 0) yaw_v = '0;
                if (yaw_v > TWO_PI_Q16) yaw_v = TWO_PI_Q16;
                myaw_next  = yaw_v[18:0];
                mx_next    = item_reg.pos_x;
                my_next    = item_reg.pos_y;
                mz_next    = item_reg.pos_z;
                state_next = ST_IDLE;
            end
            // step products
            ST_TICK_PROD:
            begin
                p0_next = 36'(planar_reg * $signed({1'b0, planar_max_reg}));
                p1_next = 36'(vert_reg * $signed({1'b0, vert_max_reg}));
                p2_next = 36'(yawc_reg * $signed({1'b0, yaw_max_reg}));
                state_next = ST_TICK_STEP;
            end
            ST_TICK_STEP:
            begin
                dl_next   = (p0_reg + 36'sd16384) >>> 15;
                dzs_next  = (p1_reg + 36'sd16384) >>> 15;
                dyaw_next = (p2_reg + 36'sd32768) >>> 16;
                th = 36'($signed({1'b0, myaw_reg})) - PI_Q16;
                neg_next = 1'b1;
                if (th > HALF_PI_Q16)
                begin
                    th = th - PI_Q16; neg_next = 1'b0;
                end
                else if (th < -HALF_PI_Q16)
                begin
                    th = th + PI_Q16; neg_next = 1'b0;
                end
                cctl.start = 1'b1;
                cctl.mode  = CMODE_ROTATE;
                zr    = 36'(GAIN_Q24) + (36'sd1 <<< (23 - FRAC_BITS));
                cx_in = (24 == FRAC_BITS) ? 36'(GAIN_Q24) : (zr >>> (24 - FRAC_BITS));
                cy_in = '0;
                cz_in = th <<< 8;
                state_next = ST_TICK_CORDIC;
            end
            ST_TICK_CORDIC:
                if (cdone) state_next = ST_TICK_MUL;
            // step is at most 17 bits plus sign, sin and cos at most 26 bits plus sign
            ST_TICK_MUL:
            begin
                rc = neg_reg ? 27'(-cx) : 27'(cx);
                rs = neg_reg ? 27'(-cy) : 27'(cy);
                mx_prod_next = 64'($signed(dl_reg[17:0]) * rc);
                my_prod_next = 64'($signed(dl_reg[17:0]) * rs);
                state_next = ST_TICK_RND;
            end
            ST_TICK_RND:
            begin
                p0_next = 36'((mx_prod_reg + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
                p1_next = 36'((my_prod_reg + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
                state_next = ST_TICK_UPD;
            end
            ST_TICK_UPD:
            begin
                ax = 34'(dx_reg) + 34'(p0_reg);
                ay = 34'(dy_reg) + 34'(p1_reg);
                az = 34'(dz_reg) + 34'(dzs_reg);
                if (absd(dx_reg, mx_reg) < {1'b0, err_x_reg}) dx_next = sat(ax);
                if (absd(dy_reg, my_reg) < {1'b0, err_y_reg}) dy_next = sat(ay);
                if (absd(dz_reg, mz_reg) < {1'b0, err_z_reg}) dz_next = sat(az);
                h = 36'($signed({1'b0, dh_reg}));
                diff = h - 36'($signed({1'b0, myaw_reg}));
                if (diff < 0) diff = -diff;
                if (diff < YAW_NEAR_Q16 || diff > YAW_FAR_Q16) h = h + dyaw_reg;
                if (h < 0) h = h + TWO_PI_Q16;
                else if (h > TWO_PI_Q16) h = h - TWO_PI_Q16;
                dh_next = h[18:0];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_next.set_x   = dx_reg;
                    out_next.set_y   = dy_reg;
                    out_next.set_z   = dz_reg;
                    out_next.set_yaw = dh_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            planar_reg    <= '0;
            vert_reg      <= '0;
            yawc_reg      <= '0;
            mx_reg        <= '0;
            my_reg        <= '0;
            mz_reg        <= '0;
            myaw_reg      <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            dz_reg        <= 32'sd65536;
            dh_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            planar_reg    <= planar_next;
            vert_reg      <= vert_next;
            yawc_reg      <= yawc_next;
            mx_reg        <= mx_next;
            my_reg        <= my_next;
            mz_reg        <= mz_next;
            myaw_reg      <= myaw_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            dz_reg        <= dz_next;
            dh_reg        <= dh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        item_reg     <= item_next;
        p0_reg       <= p0_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        offs_reg     <= offs_next;
        dl_reg       <= dl_next;
        dzs_reg      <= dzs_next;
        dyaw_reg     <= dyaw_next;
        neg_reg      <= neg_next;
        mx_prod_reg  <= mx_prod_next;
        my_prod_reg  <= my_prod_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
